### hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ps2mt_pkg.sv
// Package with the types and constants of the PS/2 mouse packet tracker.
package ps2mt_pkg;

  typedef enum logic [1:0] {
    OP_DATA         = 2'd0,
    OP_POLL_PRESS   = 2'd1,
    OP_POLL_RELEASE = 2'd2,
    OP_CLEAR_HELD   = 2'd3
  } op_t;

  localparam int BTN_COUNT      = 3;
  localparam int BTN_CODE_BITS  = 7;
  localparam int OUT_COORD_BITS = 12;
  localparam int CFG_DATA_BITS  = 12;

  localparam logic [BTN_CODE_BITS-1:0] NO_BUTTON = 7'd127;

  // Configuration register indexes.
  localparam logic REG_MAX_X = 1'b0;
  localparam logic REG_MAX_Y = 1'b1;

  localparam int MAX_X_DEFAULT = 800;
  localparam int MAX_Y_DEFAULT = 600;

  // Byte position that completes a packet.
  localparam logic [1:0] LAST_BYTE_IDX = 2'd2;

  // Button changes found in one packet.
  typedef struct packed {
    logic                     press_hit;
    logic [BTN_CODE_BITS-1:0] press_num;
    logic                     release_hit;
    logic [BTN_CODE_BITS-1:0] release_num;
  } btn_update_t;

endpackage

### hdl/ps2mt_buttons.sv
// Button edge detector: finds the highest pressed and released button of a packet.
module ps2mt_buttons
  import ps2mt_pkg::*;
(
  input  logic [BTN_COUNT-1:0] now_buttons,
  input  logic [BTN_COUNT-1:0] last_buttons,
  output btn_update_t          update
);

  logic [BTN_COUNT-1:0] rising;
  logic [BTN_COUNT-1:0] falling;

  assign rising  = now_buttons & ~last_buttons;
  assign falling = ~now_buttons & last_buttons;

  // Scanning upward lets the highest changed button win.
  always_comb begin
    update = '{press_hit: 1'b0, press_num: NO_BUTTON,
               release_hit: 1'b0, release_num: NO_BUTTON};
    for (int i = 0; i < BTN_COUNT; i++) begin
      if (rising[i]) begin
        update.press_hit = 1'b1;
        update.press_num = BTN_CODE_BITS'(i + 1);
      end
      if (falling[i]) begin
        update.release_hit = 1'b1;
        update.release_num = BTN_CODE_BITS'(i + 1);
      end
    end
  end

endmodule

### hdl/ps2mt_cursor.sv
// One cursor axis: adds a signed delta and clamps the result to 0..max.
module ps2mt_cursor #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0] pos,
  input  logic signed [8:0]     delta,
  input  logic [COORD_BITS-1:0] max_pos,
  input  logic                  move,
  output logic [COORD_BITS-1:0] pos_next
);

  localparam int SUM_BITS = COORD_BITS + 2;

  logic signed [SUM_BITS-1:0] sum;
  logic signed [SUM_BITS-1:0] limit;

  assign sum   = $signed({2'b00, pos}) + SUM_BITS'(delta);
  assign limit = $signed({2'b00, max_pos});

  // The high bound is tested first; a limit is never negative, so the order only
  // matters for readability.
  always_comb begin
    if (!move) begin
      pos_next = pos;
    end else if (sum > limit) begin
      pos_next = max_pos;
    end else if (sum < 0) begin
      pos_next = '0;
    end else begin
      pos_next = sum[COORD_BITS-1:0];
    end
  end

endmodule

### hdl/ps2_mouse_packet_tracker.sv
// Top level of the PS/2 mouse packet tracker.
// Pipeline: an accepted transaction waits in the input register until the result
// register can take it. Throughput: one transaction per cycle unless the output stalls,
// through two stages, the input register and the result register; the tracker state
// updates at the same edge as the result register.
// Reset (synchronous, active high): cursor at 0,0, all button codes 127, packet
// assembly at byte 0, limits back to 800 by 600.
module ps2_mouse_packet_tracker
  import ps2mt_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,

  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,

  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic [7:0]                data_byte,
  input  logic                      aux_flag,

  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [OUT_COORD_BITS-1:0] cursor_x,
  output logic [OUT_COORD_BITS-1:0] cursor_y,
  output logic [BTN_CODE_BITS-1:0]  pressed_button,
  output logic [BTN_CODE_BITS-1:0]  released_button,
  output logic [BTN_CODE_BITS-1:0]  held_press,
  output logic [BTN_CODE_BITS-1:0]  held_release,
  output logic                      packet_done
);

  localparam logic [COORD_BITS-1:0] MAX_X_RESET = COORD_BITS'(MAX_X_DEFAULT);
  localparam logic [COORD_BITS-1:0] MAX_Y_RESET = COORD_BITS'(MAX_Y_DEFAULT);

  // ---------------------------------------------------------------------------
  // Configuration. Written data is zero-extended or cut to the coordinate width.
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0]               max_x;
  logic [COORD_BITS-1:0]               max_y;
  logic [COORD_BITS+CFG_DATA_BITS-1:0] cfg_wide;
  logic [COORD_BITS-1:0]               cfg_coord;

  assign cfg_wide  = {{COORD_BITS{1'b0}}, cfg_data};
  assign cfg_coord = cfg_wide[COORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_x <= MAX_X_RESET;
      max_y <= MAX_Y_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_X) begin
        max_x <= cfg_coord;
      end
      if (cfg_index == REG_MAX_Y) begin
        max_y <= cfg_coord;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. It advances whenever the result register can take the
  // transaction it holds, so a new transaction enters in every cycle unless
  // the output side stalls.
  // ---------------------------------------------------------------------------
  logic       s1_valid;
  op_t        s1_op;
  logic [7:0] s1_data;
  logic       s1_aux;
  logic       fire;

  assign fire     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op   <= op_t'(op);
      s1_data <= data_byte;
      s1_aux  <= aux_flag;
    end
  end

  // ---------------------------------------------------------------------------
  // Tracker state. It changes only when the transaction in the input register
  // moves on to the result register, so back-to-back transactions always see
  // the state left by the one before.
  // ---------------------------------------------------------------------------
  logic [7:0]              pkt_b0;
  logic [7:0]              pkt_b1;
  logic [1:0]              byte_index;
  logic [BTN_COUNT-1:0]    last_buttons;
  logic [COORD_BITS-1:0]   pos_x;
  logic [COORD_BITS-1:0]   pos_y;
  logic [BTN_CODE_BITS-1:0] press_latch;
  logic [BTN_CODE_BITS-1:0] release_latch;
  logic [BTN_CODE_BITS-1:0] press_copy;
  logic [BTN_CODE_BITS-1:0] release_copy;

  logic [1:0]               byte_index_next;
  logic [BTN_COUNT-1:0]     last_buttons_next;
  logic [COORD_BITS-1:0]    pos_x_next;
  logic [COORD_BITS-1:0]    pos_y_next;
  logic [BTN_CODE_BITS-1:0] press_latch_next;
  logic [BTN_CODE_BITS-1:0] release_latch_next;
  logic [BTN_CODE_BITS-1:0] press_copy_next;
  logic [BTN_CODE_BITS-1:0] release_copy_next;

  logic is_aux_byte;
  logic finish;
  logic move;
  logic signed [8:0] delta_x;
  logic signed [8:0] delta_y;
  logic [COORD_BITS-1:0] moved_x;
  logic [COORD_BITS-1:0] moved_y;
  btn_update_t           btn_upd;

  // Only data transactions with the auxiliary flag take part in a packet; any
  // other byte from the controller is dropped.
  assign is_aux_byte = (s1_op == OP_DATA) && s1_aux;
  assign finish      = is_aux_byte && (byte_index >= LAST_BYTE_IDX);

  // A packet with no motion at all leaves the cursor untouched, even if it sits
  // above a limit that was lowered since.
  assign move    = (pkt_b1 != 8'd0) || (s1_data != 8'd0);
  assign delta_x = $signed({pkt_b1[7], pkt_b1});
  // Screen Y grows downward, so the mouse Y delta is negated; 0x80 gives +128.
  assign delta_y = -$signed({s1_data[7], s1_data});

  ps2mt_cursor #(
    .COORD_BITS(COORD_BITS)
  ) u_cursor_x (
    .pos      (pos_x),
    .delta    (delta_x),
    .max_pos  (max_x),
    .move     (move),
    .pos_next (moved_x)
  );

  ps2mt_cursor #(
    .COORD_BITS(COORD_BITS)
  ) u_cursor_y (
    .pos      (pos_y),
    .delta    (delta_y),
    .max_pos  (max_y),
    .move     (move),
    .pos_next (moved_y)
  );

  // Sign and overflow bits of the first byte are ignored; only the buttons count.
  ps2mt_buttons u_buttons (
    .now_buttons  (pkt_b0[BTN_COUNT-1:0]),
    .last_buttons (last_buttons),
    .update       (btn_upd)
  );

  always_comb begin
    byte_index_next    = byte_index;
    last_buttons_next  = last_buttons;
    pos_x_next         = pos_x;
    pos_y_next         = pos_y;
    press_latch_next   = press_latch;
    release_latch_next = release_latch;
    press_copy_next    = press_copy;
    release_copy_next  = release_copy;
    case (s1_op)
      OP_DATA: begin
        if (is_aux_byte) begin
          if (finish) begin
            byte_index_next   = 2'd0;
            pos_x_next        = moved_x;
            pos_y_next        = moved_y;
            last_buttons_next = pkt_b0[BTN_COUNT-1:0];
            if (btn_upd.press_hit) begin
              press_latch_next = btn_upd.press_num;
              press_copy_next  = btn_upd.press_num;
            end
            if (btn_upd.release_hit) begin
              release_latch_next = btn_upd.release_num;
              release_copy_next  = btn_upd.release_num;
            end
          end else begin
            byte_index_next = byte_index + 2'd1;
          end
        end
      end
      OP_POLL_PRESS: begin
        press_latch_next = NO_BUTTON;
      end
      OP_POLL_RELEASE: begin
        release_latch_next = NO_BUTTON;
      end
      OP_CLEAR_HELD: begin
        press_copy_next   = NO_BUTTON;
        release_copy_next = NO_BUTTON;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= 2'd0;
      last_buttons  <= '0;
      pos_x         <= '0;
      pos_y         <= '0;
      press_latch   <= NO_BUTTON;
      release_latch <= NO_BUTTON;
      press_copy    <= NO_BUTTON;
      release_copy  <= NO_BUTTON;
      pkt_b0        <= 8'd0;
      pkt_b1        <= 8'd0;
    end else if (fire) begin
      byte_index    <= byte_index_next;
      last_buttons  <= last_buttons_next;
      pos_x         <= pos_x_next;
      pos_y         <= pos_y_next;
      press_latch   <= press_latch_next;
      release_latch <= release_latch_next;
      press_copy    <= press_copy_next;
      release_copy  <= release_copy_next;
      if (is_aux_byte && !finish) begin
        if (byte_index == 2'd0) begin
          pkt_b0 <= s1_data;
        end else begin
          pkt_b1 <= s1_data;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. A poll shows the latch as it was before clearing; every
  // other transaction shows the latches after the step. Because polls only
  // clear, the value before the step is right for every non-data operation.
  // ---------------------------------------------------------------------------
  logic [COORD_BITS+OUT_COORD_BITS-1:0] wide_x;
  logic [COORD_BITS+OUT_COORD_BITS-1:0] wide_y;

  assign wide_x = {{OUT_COORD_BITS{1'b0}}, pos_x_next};
  assign wide_y = {{OUT_COORD_BITS{1'b0}}, pos_y_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cursor_x        <= wide_x[OUT_COORD_BITS-1:0];
      cursor_y        <= wide_y[OUT_COORD_BITS-1:0];
      pressed_button  <= (s1_op == OP_DATA) ? press_latch_next : press_latch;
      released_button <= (s1_op == OP_DATA) ? release_latch_next : release_latch;
      held_press      <= press_copy_next;
      held_release    <= release_copy_next;
      packet_done     <= finish;
    end
  end

endmodule

### hdl/ps2mt_checker.sv
// Port-level checker for the PS/2 mouse packet tracker, bound to the top level.
`include "assert_macros.svh"

module ps2mt_checker
  import ps2mt_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [OUT_COORD_BITS-1:0] cursor_x,
  input logic [OUT_COORD_BITS-1:0] cursor_y,
  input logic [BTN_CODE_BITS-1:0]  pressed_button,
  input logic [BTN_CODE_BITS-1:0]  released_button,
  input logic [BTN_CODE_BITS-1:0]  held_press,
  input logic [BTN_CODE_BITS-1:0]  held_release,
  input logic                      packet_done
);

  // A stalled result keeps its whole payload.
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(cursor_x) && $stable(cursor_y) && $stable(pressed_button) && $stable(released_button) && $stable(held_press) && $stable(held_release) && $stable(packet_done), "stalled result changed")

  // Button latches only ever hold a button number 1 to 3 or the no-button code.
  `ASSERT_CLK(a_latch_codes, out_valid |-> (pressed_button == NO_BUTTON || (pressed_button >= 7'd1 && pressed_button <= 7'd3)) && (released_button == NO_BUTTON || (released_button >= 7'd1 && released_button <= 7'd3)), "bad latch button code")

  // The untouched copies follow the same code rules.
  `ASSERT_CLK(a_held_codes, out_valid |-> (held_press == NO_BUTTON || (held_press >= 7'd1 && held_press <= 7'd3)) && (held_release == NO_BUTTON || (held_release >= 7'd1 && held_release <= 7'd3)), "bad held button code")

  // No result is offered in the cycle after reset.
  `ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !out_valid, "result valid right after reset")

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_ps2mt_checker (.*);
